/* hdl/cple_pkg.sv */
// Shared types and constants for the code-block pass/length header encoder.
// Used by cple_pass_decode and codeblock_pass_length_encoder; no dependencies.
package cple_pkg;

  localparam int PassW    = 8;   // pass count field width
  localparam int CodeLenW = 16;  // code length field width
  localparam int HdrW     = 47;  // header bits field width
  localparam int CntW     = 6;   // bit count field width
  localparam int PcodeW   = 16;  // longest pass-count code
  localparam int PcodeLenW = 5;  // holds a pass-count code length up to 16
  localparam int LpW      = 3;   // floor log2 of a pass count

  localparam logic [PassW-1:0] MaxPasses   = 8'd164;
  localparam logic [CntW-1:0]  BaseLenBits = 6'd3;

  // Decoded pass count: invalid flag, code bits, their number and floor log2 of the count
  typedef struct packed {
    logic                 invalid;
    logic [PcodeW-1:0]    code;
    logic [PcodeLenW-1:0] code_len;
    logic [LpW-1:0]       lp;
  } pass_code_t;

endpackage

/* hdl/cple_pass_decode.sv */
// Pass-count decoder: builds the variable-length pass-count code and floor log2.
// Depends on cple_pkg.
module cple_pass_decode (
  input  logic [cple_pkg::PassW-1:0] pass_count_i,
  output cple_pkg::pass_code_t       pass_code_o
);

  logic [cple_pkg::PassW-1:0] diff3;
  logic [cple_pkg::PassW-1:0] diff6;
  logic [cple_pkg::PassW-1:0] diff37;

  assign diff3  = pass_count_i - 8'd3;
  assign diff6  = pass_count_i - 8'd6;
  assign diff37 = pass_count_i - 8'd37;

  // Select the code class by pass count range
  always_comb begin
    pass_code_o = '0;
    pass_code_o.invalid = (pass_count_i == '0) || (pass_count_i > cple_pkg::MaxPasses);
    priority if (pass_count_i == 8'd1) begin
      pass_code_o.code     = 16'd0;
      pass_code_o.code_len = 5'd1;
    end else if (pass_count_i == 8'd2) begin
      pass_code_o.code     = 16'd2;
      pass_code_o.code_len = 5'd2;
    end else if (pass_count_i <= 8'd5) begin
      pass_code_o.code     = {12'd0, 2'b11, diff3[1:0]};
      pass_code_o.code_len = 5'd4;
    end else if (pass_count_i <= 8'd36) begin
      pass_code_o.code     = {7'd0, 4'hf, diff6[4:0]};
      pass_code_o.code_len = 5'd9;
    end else begin
      pass_code_o.code     = {9'h1ff, diff37[6:0]};
      pass_code_o.code_len = 5'd16;
    end
    // Floor log2: highest set bit wins
    for (int i = 0; i < cple_pkg::PassW; i++) begin
      if (pass_count_i[i]) begin
        pass_code_o.lp = cple_pkg::LpW'(i);
      end
    end
  end

endmodule

/* hdl/codeblock_pass_length_encoder.sv */
// Code-block pass-count and length header encoder, three register stages.
// A result strobes on result_valid_o once a taken start_i has passed the s1, s2 and s3 registers.
// Throughput: one item per cycle; busy_o is tied low.
// Reset: rst_ni clears the stage valid bits asynchronously; nothing is in flight.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Depends on cple_pkg and cple_pass_decode.
module codeblock_pass_length_encoder #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [cple_pkg::PassW-1:0]    pass_count_i,
  input  logic [cple_pkg::CodeLenW-1:0] code_length_i,
  output logic                          result_valid_o,
  output logic [cple_pkg::HdrW-1:0]     header_bits_o,
  output logic [cple_pkg::CntW-1:0]     bit_count_o,
  output logic                          invalid_o
);

  localparam int LenW = (LENGTH_BITS < cple_pkg::CodeLenW) ? LENGTH_BITS : cple_pkg::CodeLenW;
  localparam int LlW  = $clog2(LenW);

  // ---------------- stage 1: decode pass count and length log ----------------
  cple_pkg::pass_code_t pass_code;
  logic [LenW-1:0]      len_in;
  logic [LlW-1:0]       ll_d;

  cple_pass_decode u_pass_decode (
    .pass_count_i (pass_count_i),
    .pass_code_o  (pass_code)
  );

  assign len_in = code_length_i[LenW-1:0];

  // Find floor log2 of the length; zero maps to zero
  always_comb begin
    ll_d = '0;
    for (int i = 0; i < LenW; i++) begin
      if (len_in[i]) begin
        ll_d = LlW'(i);
      end
    end
  end

  logic                 s1_valid_q;
  cple_pkg::pass_code_t s1_pc_q;
  logic [LenW-1:0]      s1_len_q;
  logic [LlW-1:0]       s1_ll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pc_q  <= pass_code;
    s1_len_q <= len_in;
    s1_ll_q  <= ll_d;
  end

  // ---------------- stage 2: comma code and header head ----------------
  logic [cple_pkg::CntW-1:0] ll_plus1;
  logic [cple_pkg::CntW-1:0] base_len;
  logic [cple_pkg::CntW-1:0] inc;
  logic [cple_pkg::CntW-1:0] comma_len;
  logic [cple_pkg::HdrW-1:0] comma_bits;
  logic [cple_pkg::HdrW-1:0] head_d;
  logic [cple_pkg::CntW-1:0] head_len_d;
  logic [cple_pkg::CntW-1:0] nlen_d;

  assign ll_plus1   = cple_pkg::CntW'(s1_ll_q) + 6'd1;
  assign base_len   = cple_pkg::BaseLenBits + cple_pkg::CntW'(s1_pc_q.lp);
  assign inc        = (ll_plus1 > base_len) ? (ll_plus1 - base_len) : '0;
  assign comma_len  = inc + 6'd1;
  // inc ones then a zero
  assign comma_bits = (cple_pkg::HdrW'(1) << comma_len) - cple_pkg::HdrW'(2);
  assign head_d     = (cple_pkg::HdrW'(s1_pc_q.code) << comma_len) | comma_bits;
  assign head_len_d = cple_pkg::CntW'(s1_pc_q.code_len) + comma_len;
  assign nlen_d     = base_len + inc;

  logic                      s2_valid_q;
  logic                      s2_inv_q;
  logic [cple_pkg::HdrW-1:0] s2_head_q;
  logic [cple_pkg::CntW-1:0] s2_head_len_q;
  logic [cple_pkg::CntW-1:0] s2_nlen_q;
  logic [LenW-1:0]           s2_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_inv_q      <= s1_pc_q.invalid;
    s2_head_q     <= head_d;
    s2_head_len_q <= head_len_d;
    s2_nlen_q     <= nlen_d;
    s2_len_q      <= s1_len_q;
  end

  // ---------------- stage 3: append length bits, output register ----------------
  logic [cple_pkg::HdrW-1:0] hdr_d;
  logic [cple_pkg::CntW-1:0] cnt_d;

  assign hdr_d = s2_inv_q ? '0
               : ((s2_head_q << s2_nlen_q) | cple_pkg::HdrW'(s2_len_q));
  assign cnt_d = s2_inv_q ? '0 : (s2_head_len_q + s2_nlen_q);

  logic                      s3_valid_q;
  logic                      s3_inv_q;
  logic [cple_pkg::HdrW-1:0] s3_hdr_q;
  logic [cple_pkg::CntW-1:0] s3_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_inv_q <= s2_inv_q;
    s3_hdr_q <= hdr_d;
    s3_cnt_q <= cnt_d;
  end

  // Drive the result ports; the pipeline never holds off a start
  assign busy_o         = 1'b0;
  assign result_valid_o = s3_valid_q;
  assign header_bits_o  = s3_hdr_q;
  assign bit_count_o    = s3_cnt_q;
  assign invalid_o      = s3_inv_q;

endmodule
